>>> hdl/l3sbm_pkg.sv
package l3sbm_pkg;

    localparam int BYTE_BITS = 8;
    localparam int CNT_W     = $clog2(BYTE_BITS);
    localparam int TIME_W    = 8;
    localparam int IDX_W     = 3;

    // timing register indexes
    localparam logic [IDX_W-1:0] REG_CLOCK_LOW  = 3'd0;
    localparam logic [IDX_W-1:0] REG_CLOCK_HIGH = 3'd1;
    localparam logic [IDX_W-1:0] REG_MODE_SETUP = 3'd2;
    localparam logic [IDX_W-1:0] REG_MODE_HOLD  = 3'd3;
    localparam logic [IDX_W-1:0] REG_HALT       = 3'd4;

    localparam logic [TIME_W-1:0] TIME_RESET = 8'd1;

    // byte position within a transaction (saturates at later)
    localparam logic [1:0] POS_ADDR  = 2'd0;
    localparam logic [1:0] POS_FIRST = 2'd1;
    localparam logic [1:0] POS_LATER = 2'd2;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_END   = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAIM,
        ST_MODE_LOW,
        ST_HALT,
        ST_SETUP,
        ST_BIT_LOW,
        ST_BIT_HIGH,
        ST_HOLD,
        ST_RELEASE
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
    } shift_ctrl_t;

endpackage

>>> hdl/l3sbm_shifter.sv
// Byte rotator with bit counter: presents bit 0, rotates right once per bit.
// After a full byte the original value is back in place.
module l3sbm_shifter (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  l3sbm_pkg::shift_ctrl_t             ctrl,
    input  logic [l3sbm_pkg::BYTE_BITS-1:0]    load_data,
    output logic                               cur_bit,
    output logic                               last_bit,
    output logic [l3sbm_pkg::BYTE_BITS-1:0]    value
);

    logic [l3sbm_pkg::BYTE_BITS-1:0] sh_reg, sh_next;
    logic [l3sbm_pkg::CNT_W-1:0]     cnt_reg, cnt_next;

    always_comb begin
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        if (ctrl.load) begin
            sh_next  = load_data;
            cnt_next = '0;
        end else if (ctrl.shift) begin
            sh_next  = {sh_reg[0], sh_reg[l3sbm_pkg::BYTE_BITS-1:1]};
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg <= sh_next;
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign cur_bit  = sh_reg[0];
    assign last_bit = (cnt_reg == l3sbm_pkg::CNT_W'(l3sbm_pkg::BYTE_BITS - 1));
    assign value    = sh_reg;

endmodule

>>> hdl/l3_serial_bus_master.sv
// Three-wire L3 bus master. Each accepted request (start+address, write,
// read, end) is expanded into a sequence of pin phases on the m_ channel;
// each phase gives the clock/mode/data levels, the two drive enables and how
// long it is held (hold_ticks: a timing register, or zero), with last
// marking the final phase of the request. A start produces 19 phases, a
// first data byte 18, a later data byte 19 (extra mode-low halt pulse), an
// end 1; a write or read while the lines are released produces nothing.
// The sequencer issues one phase per cycle into a single output register
// when m_ready stays high; s_ready is high only while the sequencer is
// idle. The byte is shifted by one rotating shift register that steps one
// bit per clock-low/clock-high pair. Timing registers are written through
// the cfg_ port (always ready) and reset to 1.
module l3_serial_bus_master (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [l3sbm_pkg::IDX_W-1:0]       cfg_index,
    input  logic [l3sbm_pkg::TIME_W-1:0]      cfg_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_mode,
    input  logic [7:0]                        s_data_byte,
    input  logic [7:0]                        s_line_bits,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_clock_pin,
    output logic                              m_mode_pin,
    output logic                              m_data_pin,
    output logic                              m_control_enable,
    output logic                              m_data_enable,
    output logic [7:0]                        m_hold_ticks,
    output logic [7:0]                        m_read_byte,
    output logic                              m_last
);

    // timing registers
    logic [7:0] clk_low_reg, clk_high_reg, setup_reg, hold_reg, halt_reg;

    // sequencer state
    l3sbm_pkg::state_t state_reg, state_next;
    l3sbm_pkg::cmd_t   cmd_reg, cmd_next;
    logic [1:0]        pos_reg, pos_next;
    logic              claimed_reg, claimed_next;
    logic              latch_reg, latch_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic       clk_pin_reg, mode_pin_reg, data_pin_reg, ce_reg, de_reg, last_reg;
    logic [7:0] hold_ticks_reg, read_byte_reg;

    // phase being built this cycle
    logic       ph_clk, ph_mode, ph_data, ph_ce, ph_de, ph_last;
    logic [7:0] ph_hold, ph_rbyte;

    logic                   adv;
    logic                   s_acc;
    l3sbm_pkg::cmd_t        s_cmd;
    l3sbm_pkg::shift_ctrl_t sh_ctrl;
    logic                   sh_bit, sh_last;
    logic [7:0]             sh_value;
    logic                   is_read;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == l3sbm_pkg::ST_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign s_cmd     = l3sbm_pkg::cmd_t'(s_mode);
    assign adv       = !out_valid_reg || m_ready;
    assign is_read   = (cmd_reg == l3sbm_pkg::CMD_READ);

    l3sbm_shifter u_shift (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (sh_ctrl),
        .load_data ((s_cmd == l3sbm_pkg::CMD_READ) ? s_line_bits : s_data_byte),
        .cur_bit   (sh_bit),
        .last_bit  (sh_last),
        .value     (sh_value)
    );

    // timing register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_low_reg  <= l3sbm_pkg::TIME_RESET;
            clk_high_reg <= l3sbm_pkg::TIME_RESET;
            setup_reg    <= l3sbm_pkg::TIME_RESET;
            hold_reg     <= l3sbm_pkg::TIME_RESET;
            halt_reg     <= l3sbm_pkg::TIME_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                l3sbm_pkg::REG_CLOCK_LOW:  clk_low_reg  <= cfg_data;
                l3sbm_pkg::REG_CLOCK_HIGH: clk_high_reg <= cfg_data;
                l3sbm_pkg::REG_MODE_SETUP: setup_reg    <= cfg_data;
                l3sbm_pkg::REG_MODE_HOLD:  hold_reg     <= cfg_data;
                l3sbm_pkg::REG_HALT:       halt_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer: next state and phase contents
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        pos_next       = pos_reg;
        claimed_next   = claimed_reg;
        latch_next     = latch_reg;
        out_valid_next = out_valid_reg && !m_ready;
        sh_ctrl        = '0;

        ph_clk   = 1'b1;
        ph_mode  = 1'b1;
        ph_data  = latch_reg;
        ph_ce    = 1'b1;
        ph_de    = !is_read;
        ph_hold  = '0;
        ph_rbyte = '0;
        ph_last  = 1'b0;

        case (state_reg)
            l3sbm_pkg::ST_IDLE: begin
                if (s_acc) begin
                    cmd_next     = s_cmd;
                    sh_ctrl.load = 1'b1;
                    case (s_cmd)
                        l3sbm_pkg::CMD_START: begin
                            claimed_next = 1'b1;
                            latch_next   = 1'b1;
                            pos_next     = l3sbm_pkg::POS_FIRST;
                            state_next   = l3sbm_pkg::ST_CLAIM;
                        end
                        l3sbm_pkg::CMD_END: begin
                            claimed_next = 1'b0;
                            pos_next     = l3sbm_pkg::POS_ADDR;
                            state_next   = l3sbm_pkg::ST_RELEASE;
                        end
                        default: begin
                            // data byte; dropped while the lines are released
                            if (claimed_reg) begin
                                if (pos_reg == l3sbm_pkg::POS_LATER) begin
                                    state_next = l3sbm_pkg::ST_HALT;
                                end else begin
                                    state_next = l3sbm_pkg::ST_SETUP;
                                    pos_next   = pos_reg + 2'd1;
                                end
                            end
                        end
                    endcase
                end
            end
            l3sbm_pkg::ST_CLAIM: begin
                ph_data = 1'b1;
                ph_de   = 1'b1;
                if (adv) state_next = l3sbm_pkg::ST_MODE_LOW;
            end
            l3sbm_pkg::ST_MODE_LOW: begin
                ph_mode = 1'b0;
                ph_de   = 1'b1;
                ph_hold = setup_reg;
                if (adv) state_next = l3sbm_pkg::ST_BIT_LOW;
            end
            l3sbm_pkg::ST_HALT: begin
                ph_mode = 1'b0;
                ph_hold = halt_reg;
                if (adv) state_next = l3sbm_pkg::ST_SETUP;
            end
            l3sbm_pkg::ST_SETUP: begin
                ph_hold = setup_reg;
                if (adv) state_next = l3sbm_pkg::ST_BIT_LOW;
            end
            l3sbm_pkg::ST_BIT_LOW: begin
                ph_clk  = 1'b0;
                ph_mode = (cmd_reg != l3sbm_pkg::CMD_START);
                ph_data = is_read ? latch_reg : sh_bit;
                ph_hold = clk_low_reg;
                if (adv) begin
                    latch_next = ph_data;
                    state_next = l3sbm_pkg::ST_BIT_HIGH;
                end
            end
            l3sbm_pkg::ST_BIT_HIGH: begin
                ph_mode = (cmd_reg != l3sbm_pkg::CMD_START);
                ph_hold = clk_high_reg;
                if (adv) begin
                    sh_ctrl.shift = 1'b1;
                    state_next    = sh_last ? l3sbm_pkg::ST_HOLD : l3sbm_pkg::ST_BIT_LOW;
                end
            end
            l3sbm_pkg::ST_HOLD: begin
                ph_hold  = hold_reg;
                ph_rbyte = is_read ? sh_value : '0;
                ph_last  = 1'b1;
                if (adv) state_next = l3sbm_pkg::ST_IDLE;
            end
            l3sbm_pkg::ST_RELEASE: begin
                ph_ce   = 1'b0;
                ph_de   = 1'b0;
                ph_last = 1'b1;
                if (adv) state_next = l3sbm_pkg::ST_IDLE;
            end
            default: state_next = l3sbm_pkg::ST_IDLE;
        endcase

        if (state_reg != l3sbm_pkg::ST_IDLE && adv) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= l3sbm_pkg::ST_IDLE;
            cmd_reg       <= l3sbm_pkg::CMD_START;
            pos_reg       <= l3sbm_pkg::POS_ADDR;
            claimed_reg   <= 1'b0;
            latch_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            pos_reg       <= pos_next;
            claimed_reg   <= claimed_next;
            latch_reg     <= latch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // phase payload, loaded when a phase is issued
    always_ff @(posedge aclk) begin
        if (state_reg != l3sbm_pkg::ST_IDLE && adv) begin
            clk_pin_reg    <= ph_clk;
            mode_pin_reg   <= ph_mode;
            data_pin_reg   <= ph_data;
            ce_reg         <= ph_ce;
            de_reg         <= ph_de;
            hold_ticks_reg <= ph_hold;
            read_byte_reg  <= ph_rbyte;
            last_reg       <= ph_last;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_clock_pin      = clk_pin_reg;
    assign m_mode_pin       = mode_pin_reg;
    assign m_data_pin       = data_pin_reg;
    assign m_control_enable = ce_reg;
    assign m_data_enable    = de_reg;
    assign m_hold_ticks     = hold_ticks_reg;
    assign m_read_byte      = read_byte_reg;
    assign m_last           = last_reg;

endmodule

>>> hdl/l3sbm_checker.sv
module l3sbm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_control_enable,
    input logic       m_data_enable,
    input logic [7:0] m_hold_ticks,
    input logic [7:0] m_read_byte,
    input logic       m_last
);

    // stalled phase holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hold_ticks) && $stable(m_last))
        else $error("phase changed while stalled");

    // data line only driven while control lines are claimed
    a_de_ce: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data_enable |-> m_control_enable)
        else $error("data driven with control released");

    // no new request taken until the current one has issued its last phase
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("request accepted mid-sequence");

    // read byte only appears on a final phase
    a_rbyte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_read_byte != 8'd0) |-> m_last && !m_data_enable)
        else $error("read byte on a non-final phase");

endmodule

bind l3_serial_bus_master l3sbm_checker u_l3sbm_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_control_enable (m_control_enable),
    .m_data_enable    (m_data_enable),
    .m_hold_ticks     (m_hold_ticks),
    .m_read_byte      (m_read_byte),
    .m_last           (m_last)
);

>>> tb/tb_l3_serial_bus_master.sv
module tb_l3_serial_bus_master;

    // One request on the s_ channel.
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic [7:0] line_bits;
    } bus_req_t;

    // One pin phase on the m_ channel.
    typedef struct packed {
        logic       clock_pin;
        logic       mode_pin;
        logic       data_pin;
        logic       control_enable;
        logic       data_enable;
        logic [7:0] hold_ticks;
        logic [7:0] read_byte;
        logic       last;
    } pin_phase_t;

    localparam int DRAIN_CYCLES   = 40;        // > one request worth of phases
    localparam int LONG_HOLDOFF   = 300;       // receiver back-pressure stretch
    localparam int ITEMS_PER_STEP = 42;
    localparam int NUM_STEPS      = 6;
    localparam int RUN_LIMIT      = 2_000_000; // time units

    // ---------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ---------------------------------------------------------------
    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          cfg_valid   = 1'b0;
    logic                          cfg_ready;
    logic [l3sbm_pkg::IDX_W-1:0]   cfg_index   = '0;
    logic [l3sbm_pkg::TIME_W-1:0]  cfg_data    = '0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic [1:0]                    s_mode      = '0;
    logic [7:0]                    s_data_byte = '0;
    logic [7:0]                    s_line_bits = '0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic                          m_clock_pin;
    logic                          m_mode_pin;
    logic                          m_data_pin;
    logic                          m_control_enable;
    logic                          m_data_enable;
    logic [7:0]                    m_hold_ticks;
    logic [7:0]                    m_read_byte;
    logic                          m_last;

    l3_serial_bus_master u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_data_byte      (s_data_byte),
        .s_line_bits      (s_line_bits),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_clock_pin      (m_clock_pin),
        .m_mode_pin       (m_mode_pin),
        .m_data_pin       (m_data_pin),
        .m_control_enable (m_control_enable),
        .m_data_enable    (m_data_enable),
        .m_hold_ticks     (m_hold_ticks),
        .m_read_byte      (m_read_byte),
        .m_last           (m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Bus master model: timing registers and transaction state
    // ---------------------------------------------------------------
    logic [l3sbm_pkg::TIME_W-1:0] t_clock_low  = l3sbm_pkg::TIME_RESET;
    logic [l3sbm_pkg::TIME_W-1:0] t_clock_high = l3sbm_pkg::TIME_RESET;
    logic [l3sbm_pkg::TIME_W-1:0] t_mode_setup = l3sbm_pkg::TIME_RESET;
    logic [l3sbm_pkg::TIME_W-1:0] t_mode_hold  = l3sbm_pkg::TIME_RESET;
    logic [l3sbm_pkg::TIME_W-1:0] t_halt       = l3sbm_pkg::TIME_RESET;

    logic [1:0] byte_pos   = l3sbm_pkg::POS_ADDR;
    logic       claimed    = 1'b0;
    logic       data_latch = 1'b1;  // data-line output latch resets high

    bus_req_t   requests_pending[$];  // requests not yet offered
    pin_phase_t phases_due[$];        // predicted phases, oldest first

    int send_idle_pct  = 0;
    int rcv_stall_pct  = 0;
    bit pressure_armed = 1'b0;        // one long receiver hold-off on demand
    int holdoff_left   = 0;
    int mismatches     = 0;

    function automatic pin_phase_t mk_phase(logic clk, logic md, logic dat,
                                            logic ce, logic de, logic [7:0] hold);
        pin_phase_t p;
        p                = '0;
        p.clock_pin      = clk;
        p.mode_pin       = md;
        p.data_pin       = dat;
        p.control_enable = ce;
        p.data_enable    = de;
        p.hold_ticks     = hold;
        return p;
    endfunction

    // Expand one accepted request into its pin phases and update the model.
    task automatic expand_request(input bus_req_t req);
        pin_phase_t      burst[$];
        logic            de;
        l3sbm_pkg::cmd_t cmd;
        cmd = l3sbm_pkg::cmd_t'(req.mode);
        case (cmd)
            l3sbm_pkg::CMD_START: begin
                // claim: all lines high and driven, then mode low for setup,
                // address LSB first with mode low, mode back high to hold
                claimed    = 1'b1;
                data_latch = 1'b1;
                burst.push_back(mk_phase(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'd0));
                burst.push_back(mk_phase(1'b1, 1'b0, data_latch, 1'b1, 1'b1, t_mode_setup));
                for (int i = 0; i < l3sbm_pkg::BYTE_BITS; i++) begin
                    data_latch = req.data_byte[i];
                    burst.push_back(mk_phase(1'b0, 1'b0, data_latch, 1'b1, 1'b1, t_clock_low));
                    burst.push_back(mk_phase(1'b1, 1'b0, data_latch, 1'b1, 1'b1, t_clock_high));
                end
                burst.push_back(mk_phase(1'b1, 1'b1, data_latch, 1'b1, 1'b1, t_mode_hold));
                byte_pos = l3sbm_pkg::POS_FIRST;
            end
            l3sbm_pkg::CMD_END: begin
                // release is emitted even when the lines are already free
                burst.push_back(mk_phase(1'b1, 1'b1, data_latch, 1'b0, 1'b0, 8'd0));
                claimed  = 1'b0;
                byte_pos = l3sbm_pkg::POS_ADDR;
            end
            default: begin
                // data byte while released: dropped, no phases
                if (claimed) begin
                    de = (cmd == l3sbm_pkg::CMD_WRITE);
                    if (byte_pos == l3sbm_pkg::POS_LATER) begin
                        burst.push_back(mk_phase(1'b1, 1'b0, data_latch, 1'b1, de, t_halt));
                    end
                    burst.push_back(mk_phase(1'b1, 1'b1, data_latch, 1'b1, de, t_mode_setup));
                    for (int i = 0; i < l3sbm_pkg::BYTE_BITS; i++) begin
                        if (cmd == l3sbm_pkg::CMD_WRITE) begin
                            data_latch = req.data_byte[i];
                        end
                        burst.push_back(mk_phase(1'b0, 1'b1, data_latch, 1'b1, de, t_clock_low));
                        burst.push_back(mk_phase(1'b1, 1'b1, data_latch, 1'b1, de, t_clock_high));
                    end
                    burst.push_back(mk_phase(1'b1, 1'b1, data_latch, 1'b1, de, t_mode_hold));
                    // all eight sampled bits end up in the read byte
                    if (cmd == l3sbm_pkg::CMD_READ) begin
                        burst[burst.size()-1].read_byte = req.line_bits;
                    end
                    if (byte_pos != l3sbm_pkg::POS_LATER) begin
                        byte_pos = byte_pos + 2'd1;
                    end
                end
            end
        endcase
        if (burst.size() > 0) begin
            burst[burst.size()-1].last = 1'b1;
        end
        foreach (burst[k]) begin
            phases_due.push_back(burst[k]);
        end
    endtask

    // ---------------------------------------------------------------
    // Request driver: valid stays up with a fixed payload until taken
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        bus_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expand_request('{mode: s_mode, data_byte: s_data_byte,
                                 line_bits: s_line_bits});
            end
            if (!s_valid || s_ready) begin
                if (requests_pending.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    req = requests_pending.pop_front();
                    s_valid     <= 1'b1;
                    s_mode      <= req.mode;
                    s_data_byte <= req.data_byte;
                    s_line_bits <= req.line_bits;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random stalls plus one long hold-off when armed
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left = holdoff_left - 1;
            m_ready <= 1'b0;
        end else if (pressure_armed && m_valid) begin
            // output register full, sender keeps offering: input must stall
            pressure_armed = 1'b0;
            holdoff_left   = LONG_HOLDOFF;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    task automatic note_mismatch(input string what, input pin_phase_t want,
                                 input pin_phase_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: expected clk=%b mode=%b data=%b ce=%b de=%b hold=%0d rd=%h last=%b",
                     what, want.clock_pin, want.mode_pin, want.data_pin,
                     want.control_enable, want.data_enable, want.hold_ticks,
                     want.read_byte, want.last);
            $display("    got      clk=%b mode=%b data=%b ce=%b de=%b hold=%0d rd=%h last=%b",
                     got.clock_pin, got.mode_pin, got.data_pin,
                     got.control_enable, got.data_enable, got.hold_ticks,
                     got.read_byte, got.last);
        end
    endtask

    // ---------------------------------------------------------------
    // Phase monitor: every accepted phase against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        pin_phase_t got;
        pin_phase_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{clock_pin: m_clock_pin, mode_pin: m_mode_pin,
                    data_pin: m_data_pin, control_enable: m_control_enable,
                    data_enable: m_data_enable, hold_ticks: m_hold_ticks,
                    read_byte: m_read_byte, last: m_last};
            if (phases_due.size() == 0) begin
                note_mismatch("unexpected phase", '0, got);
            end else begin
                want = phases_due.pop_front();
                if (got.clock_pin      !== want.clock_pin      ||
                    got.mode_pin       !== want.mode_pin       ||
                    got.data_pin       !== want.data_pin       ||
                    got.control_enable !== want.control_enable ||
                    got.data_enable    !== want.data_enable    ||
                    got.hold_ticks     !== want.hold_ticks     ||
                    got.read_byte      !== want.read_byte      ||
                    got.last           !== want.last) begin
                    note_mismatch("phase mismatch", want, got);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic add_request(input l3sbm_pkg::cmd_t cmd, input logic [7:0] dbyte,
                               input logic [7:0] lines);
        requests_pending.push_back('{mode: cmd, data_byte: dbyte, line_bits: lines});
    endtask

    // Mostly complete transactions (start, data bytes, end) with random
    // content; the rest is loose requests and transactions left open.
    task automatic add_random_traffic(input int count);
        int added;
        int nbytes;
        added = 0;
        while (added < count) begin
            if ($urandom_range(99) < 20) begin
                add_request(l3sbm_pkg::cmd_t'($urandom_range(3)),
                            8'($urandom_range(255)), 8'($urandom_range(255)));
                added++;
            end else begin
                add_request(l3sbm_pkg::CMD_START, 8'($urandom_range(255)),
                            8'($urandom_range(255)));
                nbytes = $urandom_range(4, 1);
                for (int i = 0; i < nbytes; i++) begin
                    add_request($urandom_range(1) ? l3sbm_pkg::CMD_READ
                                                  : l3sbm_pkg::CMD_WRITE,
                                8'($urandom_range(255)), 8'($urandom_range(255)));
                end
                added += nbytes + 1;
                // sometimes leave the transaction open for the next start
                if ($urandom_range(9) != 0) begin
                    add_request(l3sbm_pkg::CMD_END, 8'($urandom_range(255)),
                                8'($urandom_range(255)));
                    added++;
                end
            end
        end
    endtask

    // Call right after a rising edge; returns after the edge that took it.
    task automatic write_reg(input logic [l3sbm_pkg::IDX_W-1:0] idx,
                             input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            l3sbm_pkg::REG_CLOCK_LOW:  t_clock_low  = val;
            l3sbm_pkg::REG_CLOCK_HIGH: t_clock_high = val;
            l3sbm_pkg::REG_MODE_SETUP: t_mode_setup = val;
            l3sbm_pkg::REG_MODE_HOLD:  t_mode_hold  = val;
            l3sbm_pkg::REG_HALT:       t_halt       = val;
            default: ;
        endcase
    endtask

    // 0: all zero, 1: all max, 2: random, else a random extreme
    function automatic logic [7:0] pick_time(input int style);
        case (style)
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'($urandom_range(255));
            default: return $urandom_range(1) ? 8'hFF : 8'h00;
        endcase
    endfunction

    // Everything offered, taken and checked, then room for a dropped
    // request still in flight before anything else may change.
    task automatic wait_drained;
        do @(posedge aclk);
        while (requests_pending.size() != 0 || s_valid || phases_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        int style;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed requests at the reset timing values
        add_request(l3sbm_pkg::CMD_WRITE, 8'h3C, 8'h00);   // data while released
        add_request(l3sbm_pkg::CMD_READ,  8'h00, 8'hFF);   // data while released
        add_request(l3sbm_pkg::CMD_END,   8'h00, 8'h00);   // end while released
        add_request(l3sbm_pkg::CMD_START, 8'h00, 8'hFF);
        add_request(l3sbm_pkg::CMD_WRITE, 8'hFF, 8'h00);   // first data byte
        add_request(l3sbm_pkg::CMD_WRITE, 8'h00, 8'hFF);   // later byte, halt pulse
        add_request(l3sbm_pkg::CMD_READ,  8'hFF, 8'hA5);
        add_request(l3sbm_pkg::CMD_READ,  8'h00, 8'h5A);
        add_request(l3sbm_pkg::CMD_WRITE, 8'h80, 8'h00);   // write after a read
        add_request(l3sbm_pkg::CMD_END,   8'hFF, 8'hFF);
        add_request(l3sbm_pkg::CMD_START, 8'hFF, 8'h00);
        add_request(l3sbm_pkg::CMD_START, 8'h01, 8'h00);   // start while claimed
        add_request(l3sbm_pkg::CMD_READ,  8'h00, 8'hFF);   // read as first data byte
        add_request(l3sbm_pkg::CMD_READ,  8'hFF, 8'h00);
        add_request(l3sbm_pkg::CMD_WRITE, 8'h01, 8'hFF);
        add_request(l3sbm_pkg::CMD_END,   8'h00, 8'h00);
        add_request(l3sbm_pkg::CMD_END,   8'h00, 8'h00);
        wait_drained;

        for (int step = 0; step < NUM_STEPS; step++) begin
            // timing settings and idling per step
            case (step)
                0: begin style = 0; send_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin style = 1; send_idle_pct = 65; rcv_stall_pct = 0;  end
                2: begin style = 2; send_idle_pct = 0;  rcv_stall_pct = 65; end
                3: begin style = 2; send_idle_pct = 26; rcv_stall_pct = 26; end
                4: begin style = 3; send_idle_pct = 0;  rcv_stall_pct = 0;  end
                default: begin style = 2; send_idle_pct = 65; rcv_stall_pct = 65; end
            endcase
            write_reg(l3sbm_pkg::REG_CLOCK_LOW,  pick_time(style));
            write_reg(l3sbm_pkg::REG_CLOCK_HIGH, pick_time(style));
            write_reg(l3sbm_pkg::REG_MODE_SETUP, pick_time(style));
            write_reg(l3sbm_pkg::REG_MODE_HOLD,  pick_time(style));
            write_reg(l3sbm_pkg::REG_HALT,       pick_time(style));
            cfg_valid <= 1'b0;
            // back-pressure step: receiver stops while requests keep coming
            if (step == 4) begin
                pressure_armed = 1'b1;
            end
            add_random_traffic(ITEMS_PER_STEP);
            wait_drained;
        end

        if (mismatches == 0 && phases_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT);
        $display("FAIL");
        $finish;
    end

endmodule
